// ----- hdl/modexp_pkg.sv -----
package modexp_pkg;

  localparam int DATA_W = 30;
  localparam int EXP_W  = 32;
  localparam int MU_W   = 31;

  localparam logic [DATA_W-1:0] MODULUS = 30'd1000000007;

  // Barrett constant floor(2^60 / MODULUS)
  localparam logic [60:0] TWO_POW_60 = 61'd1 << 60;
  localparam logic [MU_W-1:0] BARRETT_MU = MU_W'(TWO_POW_60 / 61'(MODULUS));

  typedef struct packed {
    logic load;
    logic step;
  } mm_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic step_done;
  } mm_sts_t;

endpackage

// ----- hdl/modular_exponentiation.sv -----
// Channel   Ports                         Transaction
// input     start, busy, in_base,         start high while busy is low
//           in_exponent
// result    out_valid, out_power_mod      out_valid high for one cycle
//
// One transaction steps through k exponent bits, k being the position of the
// highest set exponent bit plus one (k = 0 for a zero exponent), so at most
// min(EXP_BITS, 32) bits.
// Each exponent bit costs one pass through the four-stage modular multipliers
// (square and multiply run side by side) plus an issue step in the run state.
// Reset is synchronous and active low; it clears the controller and the
// multiplier valid chains. The receiver cannot stall: the result is shown once.
module modular_exponentiation #(
  parameter int EXP_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [modexp_pkg::DATA_W-1:0]  in_base,
  input  logic [modexp_pkg::EXP_W-1:0]   in_exponent,
  output logic                           out_valid,
  output logic [modexp_pkg::DATA_W-1:0]  out_power_mod
);

  modexp_pkg::mm_cmd_t cmd;
  modexp_pkg::mm_sts_t sts;

  modexp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy),
    .done_strobe (out_valid)
  );

  modexp_dp #(
    .EXP_BITS (EXP_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .base     (in_base),
    .exponent (in_exponent),
    .result   (out_power_mod)
  );

endmodule

// ----- hdl/modexp_modmul.sv -----
module modexp_modmul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            go,
  input  logic [modexp_pkg::DATA_W-1:0]   a,
  input  logic [modexp_pkg::DATA_W-1:0]   b,
  output logic                            done,
  output logic [modexp_pkg::DATA_W-1:0]   y
);

  localparam int PW = 2 * modexp_pkg::DATA_W;

  logic [3:0]        vld_r;
  logic [PW-1:0]     prod_r;
  logic [61:0]       q2_r;
  logic [31:0]       plo1_r;
  logic [31:0]       plo2_r;
  logic [31:0]       qm_r;
  logic [modexp_pkg::DATA_W-1:0] y_r;

  logic [61:0]       q2_nxt;
  logic [61:0]       qm_full;
  logic [31:0]       rem;
  logic [32:0]       rem_m1;
  logic [32:0]       rem_m2;
  logic [modexp_pkg::DATA_W-1:0] y_nxt;

  always_comb begin
    q2_nxt  = 62'(prod_r[PW-1:29]) * 62'(modexp_pkg::BARRETT_MU);
    qm_full = 62'(q2_r[61:31]) * 62'(modexp_pkg::MODULUS);
    // remainder is below three moduli, so 32 bits are enough
    rem     = plo2_r - qm_r;
    rem_m1  = {1'b0, rem} - 33'(modexp_pkg::MODULUS);
    rem_m2  = {1'b0, rem} - (33'(modexp_pkg::MODULUS) << 1);
    if (!rem_m2[32]) begin
      y_nxt = rem_m2[modexp_pkg::DATA_W-1:0];
    end else if (!rem_m1[32]) begin
      y_nxt = rem_m1[modexp_pkg::DATA_W-1:0];
    end else begin
      y_nxt = rem[modexp_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], go};
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(a) * PW'(b);
    q2_r   <= q2_nxt;
    plo1_r <= prod_r[31:0];
    qm_r   <= qm_full[31:0];
    plo2_r <= plo1_r;
    y_r    <= y_nxt;
  end

  assign done = vld_r[3];
  assign y    = y_r;

endmodule

// ----- hdl/modexp_dp.sv -----
module modexp_dp #(
  parameter int EXP_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  modexp_pkg::mm_cmd_t             cmd,
  output modexp_pkg::mm_sts_t             sts,
  input  logic [modexp_pkg::DATA_W-1:0]   base,
  input  logic [modexp_pkg::EXP_W-1:0]    exponent,
  output logic [modexp_pkg::DATA_W-1:0]   result
);

  localparam int EW = (EXP_BITS < modexp_pkg::EXP_W) ? EXP_BITS : modexp_pkg::EXP_W;

  logic [modexp_pkg::DATA_W-1:0] sq_r;
  logic [modexp_pkg::DATA_W-1:0] acc_r;
  logic [EW-1:0]                 exp_r;

  logic [modexp_pkg::DATA_W-1:0] base_red;
  logic [modexp_pkg::DATA_W-1:0] sq_y;
  logic [modexp_pkg::DATA_W-1:0] acc_y;
  logic                          sq_done;
  logic                          acc_done;

  // input base is below twice the modulus: one subtract reduces it
  assign base_red = (base >= modexp_pkg::MODULUS) ? base - modexp_pkg::MODULUS : base;

  modexp_modmul u_sq_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.step),
    .a     (sq_r),
    .b     (sq_r),
    .done  (sq_done),
    .y     (sq_y)
  );

  modexp_modmul u_acc_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.step),
    .a     (acc_r),
    .b     (sq_r),
    .done  (acc_done),
    .y     (acc_y)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sq_r  <= base_red;
      acc_r <= modexp_pkg::DATA_W'(1);
      exp_r <= exponent[EW-1:0];
    end else if (sts.step_done) begin
      sq_r <= sq_y;
      if (exp_r[0]) begin
        acc_r <= acc_y;
      end
      exp_r <= exp_r >> 1;
    end
  end

  assign sts.exp_zero  = (exp_r == '0);
  assign sts.step_done = sq_done & acc_done;
  assign result        = acc_r;

endmodule

// ----- hdl/modexp_ctrl.sv -----
module modexp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  modexp_pkg::mm_sts_t  sts,
  output modexp_pkg::mm_cmd_t  cmd,
  output logic                 busy,
  output logic                 done_strobe
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   strobe_r, strobe_nxt;

  always_comb begin
    state_nxt  = state_r;
    busy_nxt   = busy_r;
    strobe_nxt = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          busy_nxt  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        // stop once no set exponent bit is left
        if (sts.exp_zero) begin
          strobe_nxt = 1'b1;
          busy_nxt   = 1'b0;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sts.step_done) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        busy_nxt  = 1'b0;
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      busy_r   <= busy_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy        = busy_r;
  assign done_strobe = strobe_r;

endmodule

// ----- hdl/modexp_checker.sv -----
module modexp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [modexp_pkg::EXP_W-1:0]   in_exponent,
  input logic                           out_valid,
  input logic [modexp_pkg::DATA_W-1:0]  out_power_mod
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted transaction");

  a_strobe_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without result strobe");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_power_mod < modexp_pkg::MODULUS)
    else $error("result not reduced");

  a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_exponent == '0 |=> ##1
      (out_valid && out_power_mod == modexp_pkg::DATA_W'(1)))
    else $error("zero exponent did not give one");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (.*);

// ----- tb/sv/modular_exponentiation_test.sv -----
`timescale 1ns / 100ps

module modular_exponentiation_test;

  localparam int DATA_W = modexp_pkg::DATA_W;
  localparam int EXP_W  = modexp_pkg::EXP_W;
  localparam logic [DATA_W-1:0] MODULUS = modexp_pkg::MODULUS;

  localparam int EXP_BITS = 32;
  localparam int RANDOM_ITEMS = 1000;
  // longest transaction plus some margin
  localparam int DRAIN_CYCLES = 2 + 5 * EXP_BITS + 20;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam logic [DATA_W-1:0] MOD_MINUS_ONE = MODULUS - 30'd1;

  typedef struct {
    logic [DATA_W-1:0] base;
    logic [EXP_W-1:0]  exponent;
    bit                known;
    logic [DATA_W-1:0] power_mod;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 22;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [DATA_W-1:0] in_base;
  logic [EXP_W-1:0]  in_exponent;
  logic              out_valid;
  logic [DATA_W-1:0] out_power_mod;

  logic [DATA_W-1:0] pending_power_mod[$];
  int unsigned       mismatch_count = 0;

  // Rows with a typed result are read off by hand; the rest use the predictor.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{30'd0,          32'd0,          1'b1, 30'd1},
    '{30'd12345,      32'd0,          1'b1, 30'd1},
    '{30'h3FFFFFFF,   32'd0,          1'b1, 30'd1},
    '{30'd0,          32'd1,          1'b1, 30'd0},
    '{30'd0,          32'hFFFFFFFF,   1'b1, 30'd0},
    '{30'd1,          32'hFFFFFFFF,   1'b1, 30'd1},
    '{MOD_MINUS_ONE,  32'd1,          1'b1, MOD_MINUS_ONE},
    '{MOD_MINUS_ONE,  32'd2,          1'b1, 30'd1},
    '{MOD_MINUS_ONE,  32'hFFFFFFFF,   1'b1, MOD_MINUS_ONE},
    '{MOD_MINUS_ONE,  32'h80000000,   1'b1, 30'd1},
    '{MODULUS,        32'd5,          1'b1, 30'd0},
    '{30'd1000000008, 32'd7,          1'b1, 30'd1},
    '{30'h3FFFFFFF,   32'd1,          1'b1, 30'd73741816},
    '{30'd2,          32'd10,         1'b1, 30'd1024},
    '{30'd2,          32'd29,         1'b1, 30'd536870912},
    '{30'd2,          32'd31,         1'b1, 30'd147483634},
    '{30'd2,          32'd1000000006, 1'b1, 30'd1},
    '{30'd5,          32'd1000000006, 1'b1, 30'd1},
    '{30'd7,          32'd1000000005, 1'b0, 30'd0},
    '{30'd3,          32'h80000000,   1'b0, 30'd0},
    '{30'd123456789,  32'hAAAAAAAA,   1'b0, 30'd0},
    '{30'h3FFFFFFF,   32'h55555555,   1'b0, 30'd0}
  };

  modular_exponentiation #(
    .EXP_BITS(EXP_BITS)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_base      (in_base),
    .in_exponent  (in_exponent),
    .out_valid    (out_valid),
    .out_power_mod(out_power_mod)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [DATA_W-1:0] power_mod_of(input logic [DATA_W-1:0] base_val,
                                                      input logic [EXP_W-1:0] exp_val);
    longint unsigned running;
    longint unsigned square;
    int              scan_bits;
    running = 1;
    square = longint'(base_val) % longint'(MODULUS);
    scan_bits = (EXP_BITS > EXP_W) ? EXP_W : EXP_BITS;
    for (int i = 0; i < scan_bits; i++) begin
      if (exp_val[i])
        running = (running * square) % longint'(MODULUS);
      square = (square * square) % longint'(MODULUS);
    end
    return running[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] random_base();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DATA_W'($urandom_range(0, 32'h3FFFFFFF));
      4, 5, 9:    return DATA_W'($urandom_range(0, 1000000006));
      6:          return DATA_W'($urandom_range(0, 15));
      7:          return DATA_W'($urandom_range(1000000000, 32'h3FFFFFFF));
      default:    return DATA_W'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic logic [EXP_W-1:0] random_exponent();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 9: return $urandom;
      4, 5, 6:       return EXP_W'($urandom_range(0, 255));
      7:             return $urandom >> $urandom_range(0, 31);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'd0;
          1:       return 32'hFFFFFFFF;
          2:       return 32'h80000000;
          default: return 32'd1000000006;
        endcase
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap(input bit burst);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (burst)
      return 0;
    if (roll < 7)
      return $urandom_range(0, 3);
    if (roll < 9)
      return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Hold start until busy is low at a rising edge, then queue the expectation.
  task automatic send_operands(input logic [DATA_W-1:0] base_val,
                               input logic [EXP_W-1:0] exp_val,
                               input bit known,
                               input logic [DATA_W-1:0] typed_power_mod);
    @(negedge clk);
    start <= 1'b1;
    in_base <= base_val;
    in_exponent <= exp_val;
    forever begin
      @(posedge clk);
      if (!busy)
        break;
    end
    pending_power_mod = {pending_power_mod,
                         (known ? typed_power_mod : power_mod_of(base_val, exp_val))};
  endtask

  task automatic idle_sender(input int unsigned gap);
    if (gap != 0) begin
      @(negedge clk);
      start <= 1'b0;
      in_base <= DATA_W'($urandom);
      in_exponent <= $urandom;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin : result_check
    logic [DATA_W-1:0] want;
    if (rst_n && out_valid) begin
      if (pending_power_mod.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: power_mod=%0d", out_power_mod);
      end else begin
        want = pending_power_mod.pop_front();
        if (out_power_mod !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: power_mod expected %0d actual %0d", want, out_power_mod);
        end
      end
    end
  end

  initial begin
    bit burst;
    burst = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_base = '0;
    in_exponent = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_operands(directed_rows[i].base, directed_rows[i].exponent,
                    directed_rows[i].known, directed_rows[i].power_mod);
      idle_sender(pick_gap(1'b0));
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // switch between back-to-back stretches and gapped ones
      if (n % 50 == 0)
        burst = ($urandom_range(0, 3) == 0);
      send_operands(random_base(), random_exponent(), 1'b0, '0);
      idle_sender(pick_gap(burst));
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_power_mod.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

endmodule
